FILE: rtl/arst_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and types for the address range symbol table.
// No dependencies; compile first.
package arst_pkg;

  localparam int ADDR_W          = 32;
  localparam int TAG_W           = 32;
  localparam int STATUS_W        = 2;
  localparam int INDEX_W         = 8;
  localparam int MAX_ENTRIES_DEF = 256;

  // Item actions
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

FILE: rtl/arst_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channels for request items and result items.
// Depends on arst_pkg for field widths.
interface arst_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [arst_pkg::ADDR_W-1:0]  address;
  logic [arst_pkg::ADDR_W-1:0]  length;
  logic [arst_pkg::TAG_W-1:0]   name_tag;

  modport source (output valid, output action, output address, output length,
                  output name_tag, input ready);
  modport sink   (input valid, input action, input address, input length,
                  input name_tag, output ready);
endinterface

interface arst_out_if;
  logic                          valid;
  logic                          ready;
  logic [arst_pkg::STATUS_W-1:0] status;
  logic [arst_pkg::TAG_W-1:0]    match_tag;
  logic [arst_pkg::INDEX_W-1:0]  match_index;

  modport source (output valid, output status, output match_tag, output match_index,
                  input ready);
  modport sink   (input valid, input status, input match_tag, input match_index,
                  output ready);
endinterface

FILE: rtl/address_range_symbol_table.sv
`timescale 1ns / 1ps
// Address range symbol table: entry memory, scan sequencer and result register.
// Depends on arst_pkg and the channel interfaces in arst_ifs.sv.
//
// Usage:
//   req carries one item per valid/ready handshake. An add item (action 0)
//   stores {address, length, name_tag} in the next free slot and returns
//   status ok with the slot number, or status full when every slot is used.
//   A lookup item (action 1) returns the tag and slot of the last filled
//   entry with start <= address < start + length (end taken in 33 bits),
//   or status not found. rsp carries exactly one result per item.
// Timing:
//   An add item, or a lookup on an empty table, goes straight to the done
//   state; any other lookup scans every filled slot, then a flush state.
//   From done the result loads once the output register is free, and
//   req.ready returns as it goes valid. The table memory has one read port
//   and the scan reads one entry per cycle, compared in one subtract/compare
//   unit. req.ready is high only while no item is in progress.
// Reset: clears the fill count, so the table reads as empty; no clearing
//   pass is needed since slots at or above the fill count are never compared.
// Stall: a finished result sits in the output register until rsp.ready;
//   the next item is still accepted meanwhile and waits to deliver its own.
module address_range_symbol_table #(
  parameter int MAX_ENTRIES = arst_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  arst_in_if.sink      req,
  arst_out_if.source   rsp
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  arst_pkg::entry_t mem [MAX_ENTRIES];
  arst_pkg::entry_t rd_entry;

  logic [CNT_W-1:0]            entry_count;
  logic [IDX_W-1:0]            scan_idx;
  logic [IDX_W-1:0]            last_idx;
  logic [IDX_W-1:0]            pipe_idx;
  logic                        pipe_vld;
  logic [arst_pkg::ADDR_W-1:0] address_q;
  logic                        found;
  logic                        full_flag;
  logic [arst_pkg::TAG_W-1:0]  hit_tag;
  logic [arst_pkg::INDEX_W-1:0] hit_index;

  logic                        accept;
  logic                        is_add;
  logic                        table_full;
  logic                        load;
  logic [arst_pkg::ADDR_W-1:0] diff;
  logic                        hit;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign is_add     = (req.action == arst_pkg::ACT_ADD);
  assign table_full = (entry_count >= CNT_W'(MAX_ENTRIES));
  assign last_idx   = IDX_W'(entry_count - CNT_W'(1));
  assign load       = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // Shared range check: address inside [start, start + length)
  assign diff = address_q - rd_entry.start;
  assign hit  = (address_q >= rd_entry.start) && (diff < rd_entry.length);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (is_add || entry_count == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx == last_idx) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_DONE;
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && is_add && !table_full) begin
      mem[entry_count[IDX_W-1:0]] <= '{start: req.address, length: req.length,
                                       tag: req.name_tag};
    end
    rd_entry <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_idx    <= '0;
      pipe_vld    <= 1'b0;
      pipe_idx    <= '0;
      address_q   <= '0;
      found       <= 1'b0;
      full_flag   <= 1'b0;
      hit_tag     <= '0;
      hit_index   <= '0;
    end else begin
      state    <= state_next;
      pipe_vld <= (state == S_SCAN);
      pipe_idx <= scan_idx;
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (accept) begin
        scan_idx  <= '0;
        hit_tag   <= '0;
        address_q <= req.address;
        if (is_add) begin
          full_flag <= table_full;
          found     <= !table_full;
          hit_index <= table_full ? '0 : arst_pkg::INDEX_W'(entry_count);
          if (!table_full) begin
            entry_count <= entry_count + CNT_W'(1);
          end
        end else begin
          full_flag <= 1'b0;
          found     <= 1'b0;
          hit_index <= '0;
        end
      end else if (pipe_vld && hit) begin
        // later slots override earlier hits
        found     <= 1'b1;
        hit_tag   <= rd_entry.tag;
        hit_index <= arst_pkg::INDEX_W'(pipe_idx);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status      <= full_flag ? arst_pkg::ST_FULL :
                         found     ? arst_pkg::ST_OK : arst_pkg::ST_NOT_FOUND;
      rsp.match_tag   <= hit_tag;
      rsp.match_index <= hit_index;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_add_advances: assert property (@(posedge clk) disable iff (rst)
    accept && is_add && !table_full |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("accepted add did not advance the fill count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == arst_pkg::ST_FULL |-> table_full)
    else $error("full status while table has free slots");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == arst_pkg::ST_NOT_FOUND |->
      rsp.match_tag == '0 && rsp.match_index == '0)
    else $error("not-found result carries tag or index");

  a_empty_lookup: assert property (@(posedge clk) disable iff (rst)
    accept && !is_add && entry_count == '0 |=> state == S_DONE)
    else $error("lookup on empty table did not finish at once");

endmodule

FILE: tb/sv/tb_address_range_symbol_table.sv
`timescale 1ns / 1ps
// Self-checking bench for address_range_symbol_table: directed and random add/lookup items.
// Depends on arst_pkg, the channel interfaces in arst_ifs.sv and the block's RTL.
module tb_address_range_symbol_table;

  localparam int MAX_ENTRIES  = arst_pkg::MAX_ENTRIES_DEF;
  localparam int TOTAL_ITEMS  = 1000;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    logic [arst_pkg::STATUS_W-1:0] status;
    logic [arst_pkg::TAG_W-1:0]    tag;
    logic [arst_pkg::INDEX_W-1:0]  index;
  } table_reply_t;

  logic clk;
  logic rst = 1'b1;

  arst_in_if  req_ch ();
  arst_out_if rsp_ch ();

  address_range_symbol_table #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the range table
  logic [arst_pkg::ADDR_W-1:0] tbl_start  [MAX_ENTRIES];
  logic [arst_pkg::ADDR_W-1:0] tbl_length [MAX_ENTRIES];
  logic [arst_pkg::TAG_W-1:0]  tbl_tag    [MAX_ENTRIES];
  int                          tbl_count = 0;

  table_reply_t pending_replies[$];

  int  items_sent     = 0;
  int  mismatch_count = 0;
  int  adds_stored    = 0;
  int  adds_refused   = 0;
  int  lookup_hits    = 0;
  int  lookup_misses  = 0;
  bit  steady_flow    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Update the shadow table for one item and return the reply it must produce.
  function automatic table_reply_t apply_table_item(input logic act,
                                                    input logic [arst_pkg::ADDR_W-1:0] addr,
                                                    input logic [arst_pkg::ADDR_W-1:0] len,
                                                    input logic [arst_pkg::TAG_W-1:0] tag);
    table_reply_t r;
    logic [arst_pkg::ADDR_W:0] lo;
    logic [arst_pkg::ADDR_W:0] hi;
    int i;
    r.status = arst_pkg::ST_NOT_FOUND;
    r.tag    = '0;
    r.index  = '0;
    if (act == arst_pkg::ACT_ADD) begin
      if (tbl_count >= MAX_ENTRIES) begin
        r.status = arst_pkg::ST_FULL;
        adds_refused++;
      end else begin
        tbl_start[tbl_count]  = addr;
        tbl_length[tbl_count] = len;
        tbl_tag[tbl_count]    = tag;
        r.status = arst_pkg::ST_OK;
        r.index  = arst_pkg::INDEX_W'(tbl_count);
        tbl_count++;
        adds_stored++;
      end
      return r;
    end
    // Later entries win, so keep scanning after a hit
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_length[i] != '0) begin
        lo = {1'b0, tbl_start[i]};
        hi = lo + {1'b0, tbl_length[i]};
        if ({1'b0, addr} >= lo && {1'b0, addr} < hi) begin
          r.status = arst_pkg::ST_OK;
          r.tag    = tbl_tag[i];
          r.index  = arst_pkg::INDEX_W'(i);
        end
      end
    end
    if (r.status == arst_pkg::ST_OK) lookup_hits++;
    else lookup_misses++;
    return r;
  endfunction

  // Bias lookups toward range edges of stored entries.
  function automatic logic [arst_pkg::ADDR_W-1:0] probe_address();
    int k;
    logic [arst_pkg::ADDR_W-1:0] s;
    logic [arst_pkg::ADDR_W-1:0] l;
    if (tbl_count == 0 || $urandom_range(0, 9) < 3) return $urandom;
    k = $urandom_range(0, tbl_count - 1);
    s = tbl_start[k];
    l = tbl_length[k];
    case ($urandom_range(0, 4))
      0: return s;
      1: return s + l - 1;
      2: return s + l;
      3: return s - 1;
      default: return (l == '0) ? s : s + ($urandom % l);
    endcase
  endfunction

  function automatic logic [arst_pkg::ADDR_W-1:0] pick_range_start();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        // overlap an existing entry
        if (tbl_count == 0) return $urandom;
        k = $urandom_range(0, tbl_count - 1);
        return (tbl_length[k] == '0) ? tbl_start[k] : tbl_start[k] + ($urandom % tbl_length[k]);
      end
      7: return 32'hFFFF_0000 | $urandom_range(0, 32'h0000_FFFF);
      default: return $urandom_range(0, 32'h0000_FFFF);
    endcase
  endfunction

  function automatic logic [arst_pkg::ADDR_W-1:0] pick_range_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    else if (r < 62) return $urandom_range(1, 4096);
    else if (r < 97) return $urandom_range(1, 32'h00FF_FFFF);
    else return $urandom;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input logic act, input logic [arst_pkg::ADDR_W-1:0] addr,
                           input logic [arst_pkg::ADDR_W-1:0] len,
                           input logic [arst_pkg::TAG_W-1:0] tag);
    int gap;
    if (items_sent % 80 == 0) steady_flow = ($urandom_range(0, 3) == 0);
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.address  <= addr;
    req_ch.length   <= len;
    req_ch.name_tag <= tag;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_replies.push_back(apply_table_item(act, addr, len, tag));
    items_sent++;
  endtask

  // Result side: random stalls, compare each item against the oldest expectation
  initial begin
    table_reply_t want;
    int hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        if (rsp_ch.valid && rsp_ch.ready) begin
          if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("result with none expected: status=%0d tag=%h index=%0d",
                                      rsp_ch.status, rsp_ch.match_tag, rsp_ch.match_index));
          end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status)
              report_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
            if (rsp_ch.match_tag !== want.tag)
              report_mismatch($sformatf("match_tag %h, expected %h", rsp_ch.match_tag, want.tag));
            if (rsp_ch.match_index !== want.index)
              report_mismatch($sformatf("match_index %0d, expected %0d",
                                        rsp_ch.match_index, want.index));
          end
          hold = steady_flow ? 0 : $urandom_range(0, 5);
        end
        if (hold > 0) begin
          rsp_ch.ready <= 1'b0;
          hold--;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic test_edge_ranges();
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_0000, $urandom, $urandom);  // empty table
    send_item(arst_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, $urandom, $urandom);
    // takes a slot, never hits
    send_item(arst_pkg::ACT_ADD,    32'h0000_1000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_1000, $urandom, $urandom);
    send_item(arst_pkg::ACT_ADD,    32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_0000, $urandom, $urandom);
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_0001, $urandom, $urandom);
    // end past the top of the address space
    send_item(arst_pkg::ACT_ADD,    32'hFFFF_FFF0, 32'h0000_0020, 32'hA5A5_A5A5);
    send_item(arst_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, $urandom, $urandom);
    send_item(arst_pkg::ACT_LOOKUP, 32'hFFFF_FFEF, $urandom, $urandom);
    send_item(arst_pkg::ACT_ADD,    32'hC000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_item(arst_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, $urandom, $urandom);
    send_item(arst_pkg::ACT_LOOKUP, 32'hC000_0000, $urandom, $urandom);
    send_item(arst_pkg::ACT_LOOKUP, 32'hBFFF_FFFF, $urandom, $urandom);
    // overlapping entries, last one wins
    send_item(arst_pkg::ACT_ADD,    32'h0000_2000, 32'h0000_0100, 32'h0000_0001);
    send_item(arst_pkg::ACT_ADD,    32'h0000_2080, 32'h0000_0010, 32'h0000_0002);
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_2085, $urandom, $urandom);
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_2090, $urandom, $urandom);
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_20FF, $urandom, $urandom);
    send_item(arst_pkg::ACT_LOOKUP, 32'h0000_2100, $urandom, $urandom);
    send_item(arst_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003);
    send_item(arst_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, $urandom, $urandom);
  endtask

  task automatic test_fill_table();
    while (tbl_count < MAX_ENTRIES) begin
      if ($urandom_range(0, 9) < 6)
        send_item(arst_pkg::ACT_ADD, pick_range_start(), pick_range_length(), $urandom);
      else
        send_item(arst_pkg::ACT_LOOKUP, probe_address(), $urandom, $urandom);
    end
  endtask

  task automatic test_full_table();
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 99) < 12)
        send_item(arst_pkg::ACT_ADD, pick_range_start(), pick_range_length(), $urandom);
      else
        send_item(arst_pkg::ACT_LOOKUP, probe_address(), $urandom, $urandom);
    end
  endtask

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.action   <= arst_pkg::ACT_ADD;
    req_ch.address  <= '0;
    req_ch.length   <= '0;
    req_ch.name_tag <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_ranges();
    test_fill_table();
    test_full_table();

    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // catch any stray result after the last one
    repeat (MAX_ENTRIES + 8) @(posedge clk);

    $display("Sent %0d items: %0d adds stored, %0d adds refused on a full table.",
             items_sent, adds_stored, adds_refused);
    $display("Lookups: %0d hits, %0d misses; %0d mismatches.",
             lookup_hits, lookup_misses, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** address_range_symbol_table: PASSED **");
    end else begin
      $display("** address_range_symbol_table: FAILED **");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timeout with %0d results outstanding.", pending_replies.size());
    $display("** address_range_symbol_table: FAILED **");
    $finish;
  end

endmodule

FILE: address_range_symbol_table.f
rtl/arst_pkg.sv
rtl/arst_ifs.sv
rtl/address_range_symbol_table.sv
tb/sv/tb_address_range_symbol_table.sv
